>>> rtl/bra_pkg.sv
// Shared types, constants and helpers for the banker resource allocator.
// No dependencies; used by bra_ctrl, bra_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package bra_pkg;

  localparam int NUM_TASKS = 8;
  localparam int NUM_RES   = 4;
  localparam int UNIT_BITS = 16;
  localparam int TASK_W    = 3;
  localparam int RES_W     = 2;
  localparam int WORK_W    = UNIT_BITS + TASK_W + 1;
  localparam int TCNT_W    = 4;
  localparam int ADDR_W    = 5;

  typedef logic [UNIT_BITS-1:0] unit_t;
  typedef logic [NUM_TASKS-1:0] tmask_t;
  typedef logic [TASK_W-1:0]    task_t;
  typedef logic [RES_W-1:0]     res_t;
  typedef logic [WORK_W-1:0]    work_t;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_INITIATE  = 3'd1,
    OP_REQUEST   = 3'd2,
    OP_RELEASE   = 3'd3,
    OP_TERMINATE = 3'd4,
    OP_CYCLE_END = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RS_DONE    = 2'd0,
    RS_BLOCKED = 2'd1,
    RS_ABORTED = 2'd2
  } rstat_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_TCOUNT  = 3'd1,
    REG_TOTAL_0 = 3'd2,
    REG_TOTAL_1 = 3'd3,
    REG_TOTAL_2 = 3'd4,
    REG_TOTAL_3 = 3'd5
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SAFE,
    ST_DEADLOCK,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_EXEC,
    DP_SAFE_STEP,
    DP_DL_STEP,
    DP_OUT
  } cmd_t;

  typedef struct packed {
    logic need_safe;
    logic need_dl;
    logic safe_last;
    logic dl_last;
  } dp_stat_t;

  function automatic unit_t sat_add(input unit_t a, input unit_t b);
    logic [UNIT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UNIT_BITS] ? '1 : s[UNIT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/bra_ctrl.sv
// Controller state machine: sequences accept, execute, safety scan,
// deadlock resolution and result hand-off. Depends on bra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  bra_pkg::dp_stat_t      stat,
  output bra_pkg::cmd_t          cmd
);

  bra_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bra_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = bra_pkg::DP_NONE;
    case (state_r)
      bra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = bra_pkg::DP_LOAD;
          state_nxt = bra_pkg::ST_EXEC;
        end
      end
      bra_pkg::ST_EXEC: begin
        cmd = bra_pkg::DP_EXEC;
        if (stat.need_safe) begin
          state_nxt = bra_pkg::ST_SAFE;
        end else if (stat.need_dl) begin
          state_nxt = bra_pkg::ST_DEADLOCK;
        end else begin
          state_nxt = bra_pkg::ST_DONE;
        end
      end
      bra_pkg::ST_SAFE: begin
        cmd = bra_pkg::DP_SAFE_STEP;
        if (stat.safe_last) begin
          state_nxt = bra_pkg::ST_DONE;
        end
      end
      bra_pkg::ST_DEADLOCK: begin
        cmd = bra_pkg::DP_DL_STEP;
        if (stat.dl_last) begin
          state_nxt = bra_pkg::ST_DONE;
        end
      end
      bra_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd           = bra_pkg::DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = bra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bra_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/bra_dp.sv
// Datapath: allocation tables, task flags, safety scan and deadlock
// resolution registers, result registers. Depends on bra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bra_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  bra_pkg::cmd_t          cmd,
  output bra_pkg::dp_stat_t      stat,
  input  wire logic              mode,
  input  wire logic [bra_pkg::TCNT_W-1:0] task_count,
  input  bra_pkg::unit_t         total_units [bra_pkg::NUM_RES],
  input  wire logic [2:0]        in_req_type,
  input  bra_pkg::task_t         in_task_id,
  input  bra_pkg::res_t          in_res_type,
  input  bra_pkg::unit_t         in_units,
  output logic [1:0]             out_status,
  output bra_pkg::tmask_t        out_aborted_mask,
  output bra_pkg::unit_t         out_available_now
);

  localparam int NT = bra_pkg::NUM_TASKS;
  localparam int NR = bra_pkg::NUM_RES;
  localparam bra_pkg::task_t IDX_LAST = bra_pkg::TASK_W'(NT - 1);

  bra_pkg::unit_t  avail_r [NR], avail_nxt [NR];
  bra_pkg::unit_t  pend_r [NR], pend_nxt [NR];
  bra_pkg::unit_t  claim_r [NT][NR], claim_nxt [NT][NR];
  bra_pkg::unit_t  held_r [NT][NR], held_nxt [NT][NR];
  bra_pkg::unit_t  rem_r [NT][NR], rem_nxt [NT][NR];
  bra_pkg::tmask_t term_r, term_nxt, abrt_r, abrt_nxt, blk_r, blk_nxt;
  bra_pkg::res_t   btype_r [NT], btype_nxt [NT];
  bra_pkg::unit_t  bunits_r [NT], bunits_nxt [NT];

  bra_pkg::work_t  work_r [NR], work_nxt [NR];
  bra_pkg::tmask_t left_r, left_nxt;
  logic            prog_r, prog_nxt;
  bra_pkg::task_t  idx_r, idx_nxt;
  bra_pkg::unit_t  oh_r, oh_nxt, orem_r, orem_nxt;

  bra_pkg::op_t    op_r, op_nxt;
  bra_pkg::task_t  t_r, t_nxt;
  bra_pkg::res_t   r_r, r_nxt;
  bra_pkg::unit_t  u_r, u_nxt;
  bra_pkg::rstat_t status_r, status_nxt;
  bra_pkg::tmask_t amask_r, amask_nxt;

  logic [1:0]      out_status_r, out_status_nxt;
  bra_pkg::tmask_t out_amask_r, out_amask_nxt;
  bra_pkg::unit_t  out_avail_r, out_avail_nxt;

  logic [bra_pkg::TCNT_W-1:0] nt_eff;
  bra_pkg::tmask_t live;
  logic            tok;
  logic            fits;
  logic            prog_now;
  bra_pkg::tmask_t left_fin;
  logic            dl_fitany;
  logic            stuck;
  bra_pkg::task_t  low;

  always_comb begin
    nt_eff = (task_count > bra_pkg::TCNT_W'(NT)) ? bra_pkg::TCNT_W'(NT) : task_count;
    for (int i = 0; i < NT; i++) begin
      live[i] = (bra_pkg::TCNT_W'(i) < nt_eff) & ~term_r[i] & ~abrt_r[i];
    end
    tok = live[t_r];

    fits = left_r[idx_r];
    for (int k = 0; k < NR; k++) begin
      if (work_r[k] < bra_pkg::WORK_W'(rem_r[idx_r][k])) begin
        fits = 1'b0;
      end
    end
    prog_now = prog_r | fits;
    left_fin = left_r;
    if (fits) begin
      left_fin[idx_r] = 1'b0;
    end

    dl_fitany = 1'b0;
    low       = '0;
    for (int i = NT - 1; i >= 0; i--) begin
      if (live[i]) begin
        low = bra_pkg::TASK_W'(i);
        if (avail_r[btype_r[i]] >= bunits_r[i]) begin
          dl_fitany = 1'b1;
        end
      end
    end
    stuck = (live != '0) && ((live & ~blk_r) == '0) && !dl_fitany;

    stat.need_safe = (op_r == bra_pkg::OP_REQUEST) && tok && mode &&
                     !(u_r > rem_r[t_r][r_r]) && (u_r <= avail_r[r_r]);
    stat.need_dl   = (op_r == bra_pkg::OP_CYCLE_END) && !mode;
    stat.safe_last = (idx_r == IDX_LAST) && !prog_now;
    stat.dl_last   = !stuck;
  end

  always_comb begin
    avail_nxt  = avail_r;
    pend_nxt   = pend_r;
    claim_nxt  = claim_r;
    held_nxt   = held_r;
    rem_nxt    = rem_r;
    term_nxt   = term_r;
    abrt_nxt   = abrt_r;
    blk_nxt    = blk_r;
    btype_nxt  = btype_r;
    bunits_nxt = bunits_r;
    work_nxt   = work_r;
    left_nxt   = left_r;
    prog_nxt   = prog_r;
    idx_nxt    = idx_r;
    oh_nxt     = oh_r;
    orem_nxt   = orem_r;
    op_nxt     = op_r;
    t_nxt      = t_r;
    r_nxt      = r_r;
    u_nxt      = u_r;
    status_nxt = status_r;
    amask_nxt  = amask_r;
    out_status_nxt = out_status_r;
    out_amask_nxt  = out_amask_r;
    out_avail_nxt  = out_avail_r;
    case (cmd)
      bra_pkg::DP_LOAD: begin
        op_nxt     = bra_pkg::op_t'(in_req_type);
        t_nxt      = in_task_id;
        r_nxt      = in_res_type;
        u_nxt      = in_units;
        status_nxt = bra_pkg::RS_DONE;
        amask_nxt  = '0;
      end
      bra_pkg::DP_EXEC: begin
        case (op_r)
          bra_pkg::OP_START: begin
            for (int k = 0; k < NR; k++) begin
              avail_nxt[k] = total_units[k];
              pend_nxt[k]  = '0;
            end
            for (int i = 0; i < NT; i++) begin
              for (int k = 0; k < NR; k++) begin
                claim_nxt[i][k] = '0;
                held_nxt[i][k]  = '0;
                rem_nxt[i][k]   = '0;
              end
              btype_nxt[i]  = '0;
              bunits_nxt[i] = '0;
            end
            term_nxt = '0;
            abrt_nxt = '0;
            blk_nxt  = '0;
          end
          bra_pkg::OP_CYCLE_END: begin
            if (mode) begin
              for (int k = 0; k < NR; k++) begin
                avail_nxt[k] = bra_pkg::sat_add(avail_r[k], pend_r[k]);
                pend_nxt[k]  = '0;
              end
            end
          end
          bra_pkg::OP_TERMINATE: begin
            if (!tok) begin
              status_nxt = abrt_r[t_r] ? bra_pkg::RS_ABORTED : bra_pkg::RS_DONE;
            end else begin
              term_nxt[t_r] = 1'b1;
              blk_nxt[t_r]  = 1'b0;
              for (int k = 0; k < NR; k++) begin
                pend_nxt[k]     = bra_pkg::sat_add(pend_r[k], held_r[t_r][k]);
                held_nxt[t_r][k] = '0;
                rem_nxt[t_r][k]  = claim_r[t_r][k];
              end
            end
          end
          bra_pkg::OP_INITIATE: begin
            if (!tok) begin
              status_nxt = abrt_r[t_r] ? bra_pkg::RS_ABORTED : bra_pkg::RS_DONE;
            end else if (mode && (u_r > avail_r[r_r])) begin
              abrt_nxt[t_r]  = 1'b1;
              blk_nxt[t_r]   = 1'b0;
              amask_nxt[t_r] = 1'b1;
              status_nxt     = bra_pkg::RS_ABORTED;
            end else begin
              claim_nxt[t_r][r_r] = u_r;
              rem_nxt[t_r][r_r]   = u_r;
            end
          end
          bra_pkg::OP_RELEASE: begin
            if (!tok) begin
              status_nxt = abrt_r[t_r] ? bra_pkg::RS_ABORTED : bra_pkg::RS_DONE;
            end else begin
              if (u_r < held_r[t_r][r_r]) begin
                pend_nxt[r_r]        = bra_pkg::sat_add(pend_r[r_r], u_r);
                held_nxt[t_r][r_r]   = held_r[t_r][r_r] - u_r;
                rem_nxt[t_r][r_r]    = bra_pkg::sat_add(rem_r[t_r][r_r], u_r);
              end else begin
                pend_nxt[r_r]        = bra_pkg::sat_add(pend_r[r_r], held_r[t_r][r_r]);
                held_nxt[t_r][r_r]   = '0;
                rem_nxt[t_r][r_r]    = bra_pkg::sat_add(rem_r[t_r][r_r],
                                                        held_r[t_r][r_r]);
              end
            end
          end
          bra_pkg::OP_REQUEST: begin
            if (!tok) begin
              status_nxt = abrt_r[t_r] ? bra_pkg::RS_ABORTED : bra_pkg::RS_DONE;
            end else if (mode && (u_r > rem_r[t_r][r_r])) begin
              for (int k = 0; k < NR; k++) begin
                pend_nxt[k]      = bra_pkg::sat_add(pend_r[k], held_r[t_r][k]);
                held_nxt[t_r][k] = '0;
                rem_nxt[t_r][k]  = claim_r[t_r][k];
              end
              abrt_nxt[t_r]  = 1'b1;
              blk_nxt[t_r]   = 1'b0;
              amask_nxt[t_r] = 1'b1;
              status_nxt     = bra_pkg::RS_ABORTED;
            end else if (u_r <= avail_r[r_r]) begin
              avail_nxt[r_r]      = avail_r[r_r] - u_r;
              held_nxt[t_r][r_r]  = bra_pkg::sat_add(held_r[t_r][r_r], u_r);
              rem_nxt[t_r][r_r]   = (rem_r[t_r][r_r] >= u_r) ? rem_r[t_r][r_r] - u_r : '0;
              if (mode) begin
                oh_nxt   = held_r[t_r][r_r];
                orem_nxt = rem_r[t_r][r_r];
                for (int k = 0; k < NR; k++) begin
                  work_nxt[k] = bra_pkg::WORK_W'(avail_r[k]);
                end
                work_nxt[r_r] = bra_pkg::WORK_W'(avail_r[r_r] - u_r);
                left_nxt = live;
                prog_nxt = 1'b0;
                idx_nxt  = '0;
              end else begin
                blk_nxt[t_r] = 1'b0;
              end
            end else begin
              blk_nxt[t_r]    = 1'b1;
              btype_nxt[t_r]  = r_r;
              bunits_nxt[t_r] = u_r;
              status_nxt      = bra_pkg::RS_BLOCKED;
            end
          end
          default: begin
            status_nxt = bra_pkg::RS_DONE;
          end
        endcase
      end
      bra_pkg::DP_SAFE_STEP: begin
        if (fits) begin
          for (int k = 0; k < NR; k++) begin
            work_nxt[k] = work_r[k] + bra_pkg::WORK_W'(held_r[idx_r][k]);
          end
        end
        left_nxt = left_fin;
        idx_nxt  = idx_r + 1'b1;
        prog_nxt = prog_now;
        if (idx_r == IDX_LAST) begin
          prog_nxt = 1'b0;
          if (!prog_now) begin
            if (left_fin != '0) begin
              avail_nxt[r_r]      = avail_r[r_r] + u_r;
              held_nxt[t_r][r_r]  = oh_r;
              rem_nxt[t_r][r_r]   = orem_r;
              blk_nxt[t_r]        = 1'b1;
              btype_nxt[t_r]      = r_r;
              bunits_nxt[t_r]     = u_r;
              status_nxt          = bra_pkg::RS_BLOCKED;
            end else begin
              blk_nxt[t_r] = 1'b0;
            end
          end
        end
      end
      bra_pkg::DP_DL_STEP: begin
        if (stuck) begin
          for (int k = 0; k < NR; k++) begin
            avail_nxt[k]     = bra_pkg::sat_add(avail_r[k], held_r[low][k]);
            rem_nxt[low][k]  = bra_pkg::sat_add(rem_r[low][k], held_r[low][k]);
            held_nxt[low][k] = '0;
          end
          abrt_nxt[low]  = 1'b1;
          blk_nxt[low]   = 1'b0;
          amask_nxt[low] = 1'b1;
        end else begin
          for (int k = 0; k < NR; k++) begin
            avail_nxt[k] = bra_pkg::sat_add(avail_r[k], pend_r[k]);
            pend_nxt[k]  = '0;
          end
          status_nxt = (amask_r != '0) ? bra_pkg::RS_ABORTED : bra_pkg::RS_DONE;
        end
      end
      bra_pkg::DP_OUT: begin
        out_status_nxt = status_r;
        out_amask_nxt  = amask_r;
        out_avail_nxt  = avail_r[r_r];
      end
      default: begin
        op_nxt = op_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NR; k++) begin
        avail_r[k] <= '0;
        pend_r[k]  <= '0;
      end
      for (int i = 0; i < NT; i++) begin
        for (int k = 0; k < NR; k++) begin
          claim_r[i][k] <= '0;
          held_r[i][k]  <= '0;
          rem_r[i][k]   <= '0;
        end
        btype_r[i]  <= '0;
        bunits_r[i] <= '0;
      end
      term_r   <= '0;
      abrt_r   <= '0;
      blk_r    <= '0;
      prog_r   <= 1'b0;
      idx_r    <= '0;
      left_r   <= '0;
      status_r <= bra_pkg::RS_DONE;
      amask_r  <= '0;
    end else begin
      avail_r  <= avail_nxt;
      pend_r   <= pend_nxt;
      claim_r  <= claim_nxt;
      held_r   <= held_nxt;
      rem_r    <= rem_nxt;
      btype_r  <= btype_nxt;
      bunits_r <= bunits_nxt;
      term_r   <= term_nxt;
      abrt_r   <= abrt_nxt;
      blk_r    <= blk_nxt;
      prog_r   <= prog_nxt;
      idx_r    <= idx_nxt;
      left_r   <= left_nxt;
      status_r <= status_nxt;
      amask_r  <= amask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r       <= work_nxt;
    oh_r         <= oh_nxt;
    orem_r       <= orem_nxt;
    op_r         <= op_nxt;
    t_r          <= t_nxt;
    r_r          <= r_nxt;
    u_r          <= u_nxt;
    out_status_r <= out_status_nxt;
    out_amask_r  <= out_amask_nxt;
    out_avail_r  <= out_avail_nxt;
  end

  assign out_status        = out_status_r;
  assign out_aborted_mask  = out_amask_r;
  assign out_available_now = out_avail_r;

endmodule
`default_nettype wire

>>> rtl/banker_resource_allocator_core.sv
// Top level of the banker resource allocator: configuration register file
// and the controller/datapath pair. Depends on bra_pkg, bra_ctrl, bra_dp.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | ports                                         | transaction
//  --------+-----------------------------------------------+-----------------------------
//  in      | in_valid/in_ready, req_type task_id res_type units | one command
//  out     | out_valid/out_ready, status aborted_mask available_now | one result per command
//  cfg     | APB: psel penable pwrite paddr pwdata prdata pready | one register write/read
//
// Each command passes through load, execute, any work phase and output. A banker request that fits
// runs the safety scan, one task per cycle, repeating its pass over the tasks while a pass makes progress.
// Optimistic cycle end aborts the lowest live task per step while stuck, then adds pending units.
// One command at a time; the next is taken while a result waits in the output register.
// rst_n is synchronous; reset clears tables, flags and loads register defaults.
module banker_resource_allocator_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_req_type,
  input  wire logic [2:0]                 in_task_id,
  input  wire logic [1:0]                 in_res_type,
  input  wire logic [15:0]                in_units,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [7:0]                      out_aborted_mask,
  output logic [15:0]                     out_available_now,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bra_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic                       mode_r;
  logic [bra_pkg::TCNT_W-1:0] tcount_r;
  bra_pkg::unit_t             total_r [bra_pkg::NUM_RES];
  bra_pkg::reg_t              reg_sel;
  logic                       wr_en;

  bra_pkg::cmd_t     cmd;
  bra_pkg::dp_stat_t stat;

  assign reg_sel    = bra_pkg::reg_t'(cfg_paddr[bra_pkg::ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      tcount_r <= bra_pkg::TCNT_W'(bra_pkg::NUM_TASKS);
      for (int k = 0; k < bra_pkg::NUM_RES; k++) begin
        total_r[k] <= '0;
      end
    end else if (wr_en) begin
      case (reg_sel)
        bra_pkg::REG_MODE:    mode_r     <= cfg_pwdata[0];
        bra_pkg::REG_TCOUNT:  tcount_r   <= cfg_pwdata[bra_pkg::TCNT_W-1:0];
        bra_pkg::REG_TOTAL_0: total_r[0] <= cfg_pwdata[bra_pkg::UNIT_BITS-1:0];
        bra_pkg::REG_TOTAL_1: total_r[1] <= cfg_pwdata[bra_pkg::UNIT_BITS-1:0];
        bra_pkg::REG_TOTAL_2: total_r[2] <= cfg_pwdata[bra_pkg::UNIT_BITS-1:0];
        bra_pkg::REG_TOTAL_3: total_r[3] <= cfg_pwdata[bra_pkg::UNIT_BITS-1:0];
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bra_pkg::REG_MODE:    cfg_prdata = {31'b0, mode_r};
      bra_pkg::REG_TCOUNT:  cfg_prdata = 32'(tcount_r);
      bra_pkg::REG_TOTAL_0: cfg_prdata = 32'(total_r[0]);
      bra_pkg::REG_TOTAL_1: cfg_prdata = 32'(total_r[1]);
      bra_pkg::REG_TOTAL_2: cfg_prdata = 32'(total_r[2]);
      bra_pkg::REG_TOTAL_3: cfg_prdata = 32'(total_r[3]);
      default:              cfg_prdata = '0;
    endcase
  end

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .mode              (mode_r),
    .task_count        (tcount_r),
    .total_units       (total_r),
    .in_req_type       (in_req_type),
    .in_task_id        (in_task_id),
    .in_res_type       (in_res_type),
    .in_units          (in_units),
    .out_status        (out_status),
    .out_aborted_mask  (out_aborted_mask),
    .out_available_now (out_available_now)
  );

endmodule
`default_nettype wire
